>>> rtl/core/ufe_pkg.sv
package ufe_pkg;

    // ring sizes, each ring keeps one slot empty
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);

    // reported receive count saturates at this value
    localparam int COUNT_W   = 6;
    localparam int COUNT_MAX = 63;

    // commands
    localparam logic [2:0] CMD_LINE_RECEIVE = 3'd0;
    localparam logic [2:0] CMD_LINE_READY   = 3'd1;
    localparam logic [2:0] CMD_HOST_WRITE   = 3'd2;
    localparam logic [2:0] CMD_HOST_READ    = 3'd3;
    localparam logic [2:0] CMD_STATUS       = 3'd4;

    // error flag bit for a dropped receive byte
    localparam int FLAG_OVERFLOW_BIT = 3;

    // input beat
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic [2:0] line_status;
    } t_cmd;

    // result beat
    typedef struct packed {
        logic         line_out_valid;
        logic [7:0]   line_out_byte;
        logic         read_valid;
        logic [7:0]   read_byte;
        logic         write_accepted;
        logic [COUNT_W-1:0] rx_count;
        logic [3:0]   error_flags;
        logic         tx_pending;
    } t_result;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

>>> rtl/core/uart_buffered_fifo_engine.sv
// Buffered serial-port core: a receive ring and a transmit ring, each of 64 entries holding
// at most 63 bytes. A command beat is taken when i_start is high and o_busy is low; the
// block then stays busy in its execute state while it updates the ring pointers and flags.
// The result beat is registered at the edge after the accept edge and sits on o_result with
// o_done high for exactly one cycle, while o_busy is already low, so a new command can be
// taken at the edge that captures the result. The block cannot take a new command while
// busy; each command passes through the registered read of the ring memories at the
// accept edge and then the execute state. The result cannot be held off: capture it
// whenever o_done is high. No clearing pass is needed after reset.
module uart_buffered_fifo_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ufe_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output ufe_pkg::t_result o_result
);
    import ufe_pkg::*;

    t_ctrl ctrl;

    // sequencing
    ufe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_ctrl  (ctrl)
    );

    // rings, pointers and flags
    ufe_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_cmd    (i_cmd),
        .o_result (o_result)
    );

    // an accepted beat always leads to busy, then to the result strobe
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not make the block busy");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_done)
        else $error("busy cycle not followed by result strobe");

    // result strobe comes only from an accepted beat and is never doubled
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while still busy");

endmodule

>>> rtl/core/ufe_ctrl.sv
module ufe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output ufe_pkg::t_ctrl o_ctrl
);
    import ufe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // state register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_ctrl.exec;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        o_busy      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.load = i_start;
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                o_busy      = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

>>> rtl/core/ufe_datapath.sv
module ufe_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ufe_pkg::t_ctrl   i_ctrl,
    input  ufe_pkg::t_cmd    i_cmd,
    output ufe_pkg::t_result o_result
);
    import ufe_pkg::*;

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    t_cmd       r_cmd;
    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;
    t_result    r_result;
    t_result    n_result;

    logic [RX_PTR_W-1:0] r_rx_wr_ptr, n_rx_wr_ptr;
    logic [RX_PTR_W-1:0] r_rx_rd_ptr, n_rx_rd_ptr;
    logic [TX_PTR_W-1:0] r_tx_wr_ptr, n_tx_wr_ptr;
    logic [TX_PTR_W-1:0] r_tx_rd_ptr, n_tx_rd_ptr;
    logic [3:0]          r_errors, n_errors;

    logic [RX_PTR_W-1:0] rx_wr_adv;
    logic [RX_PTR_W-1:0] rx_rd_adv;
    logic [TX_PTR_W-1:0] tx_wr_adv;
    logic [TX_PTR_W-1:0] tx_rd_adv;
    logic                rx_full;
    logic                rx_empty;
    logic                tx_full;
    logic                tx_empty;
    logic                rx_push;
    logic                tx_push;
    logic [RX_PTR_W:0]   rx_fill;
    logic [RX_PTR_W+COUNT_W:0] rx_fill_x;

    // pointer wrap
    assign rx_wr_adv = (r_rx_wr_ptr == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_rx_wr_ptr + 1'b1;
    assign rx_rd_adv = (r_rx_rd_ptr == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_rx_rd_ptr + 1'b1;
    assign tx_wr_adv = (r_tx_wr_ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_tx_wr_ptr + 1'b1;
    assign tx_rd_adv = (r_tx_rd_ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_tx_rd_ptr + 1'b1;

    assign rx_full  = (rx_wr_adv == r_rx_rd_ptr);
    assign rx_empty = (r_rx_rd_ptr == r_rx_wr_ptr);
    assign tx_full  = (tx_wr_adv == r_tx_rd_ptr);
    assign tx_empty = (r_tx_rd_ptr == r_tx_wr_ptr);

    assign rx_push = i_ctrl.exec && (r_cmd.command == CMD_LINE_RECEIVE) && !rx_full;
    assign tx_push = i_ctrl.exec && (r_cmd.command == CMD_HOST_WRITE) && !tx_full;

    // command latch and ring reads at the accept edge
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd      <= i_cmd;
            r_rx_rdata <= rx_mem[r_rx_rd_ptr];
            r_tx_rdata <= tx_mem[r_tx_rd_ptr];
        end
    end

    // ring writes
    always_ff @(posedge i_clk) begin
        if (rx_push) rx_mem[r_rx_wr_ptr] <= r_cmd.data_byte;
        if (tx_push) tx_mem[r_tx_wr_ptr] <= r_cmd.data_byte;
    end

    // command execution
    always_comb begin
        n_rx_wr_ptr = r_rx_wr_ptr;
        n_rx_rd_ptr = r_rx_rd_ptr;
        n_tx_wr_ptr = r_tx_wr_ptr;
        n_tx_rd_ptr = r_tx_rd_ptr;
        n_errors    = r_errors;
        n_result    = '0;
        case (r_cmd.command)
            CMD_LINE_RECEIVE: begin
                n_errors = {rx_full, r_cmd.line_status};
                if (!rx_full) n_rx_wr_ptr = rx_wr_adv;
            end
            CMD_LINE_READY: begin
                if (!tx_empty) begin
                    n_result.line_out_valid = 1'b1;
                    n_result.line_out_byte  = r_tx_rdata;
                    n_tx_rd_ptr             = tx_rd_adv;
                end
            end
            CMD_HOST_WRITE: begin
                if (!tx_full) begin
                    n_result.write_accepted = 1'b1;
                    n_tx_wr_ptr             = tx_wr_adv;
                end
            end
            CMD_HOST_READ: begin
                if (!rx_empty) begin
                    n_result.read_valid = 1'b1;
                    n_result.read_byte  = r_rx_rdata;
                    n_rx_rd_ptr         = rx_rd_adv;
                end
            end
            default: begin
                n_errors = r_errors;
            end
        endcase
        n_result.error_flags = n_errors;
        if (r_cmd.command == CMD_STATUS) n_errors = '0;
        n_result.tx_pending = (n_tx_rd_ptr != n_tx_wr_ptr);
        n_result.rx_count   = (rx_fill_x > (RX_PTR_W + COUNT_W + 1)'(COUNT_MAX))
                            ? COUNT_W'(COUNT_MAX) : rx_fill_x[COUNT_W-1:0];
    end

    // receive fill after the step
    always_comb begin
        if (n_rx_wr_ptr >= n_rx_rd_ptr) begin
            rx_fill = {1'b0, n_rx_wr_ptr} - {1'b0, n_rx_rd_ptr};
        end else begin
            rx_fill = (RX_PTR_W + 1)'(RX_DEPTH) - {1'b0, n_rx_rd_ptr} + {1'b0, n_rx_wr_ptr};
        end
        rx_fill_x = {{COUNT_W{1'b0}}, rx_fill};
    end

    // ring pointers and error flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr_ptr <= '0;
            r_rx_rd_ptr <= '0;
            r_tx_wr_ptr <= '0;
            r_tx_rd_ptr <= '0;
            r_errors    <= '0;
        end else if (i_ctrl.exec) begin
            r_rx_wr_ptr <= n_rx_wr_ptr;
            r_rx_rd_ptr <= n_rx_rd_ptr;
            r_tx_wr_ptr <= n_tx_wr_ptr;
            r_tx_rd_ptr <= n_tx_rd_ptr;
            r_errors    <= n_errors;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) r_result <= n_result;
    end

    assign o_result = r_result;

endmodule
